### hw/rtl/amlc_pkg.sv
// auto-mouse layer controller: shared types, codes and constants
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package amlc_pkg;

  // sizes
  localparam int NumPositions = 64;
  localparam int NumLayers    = 32;
  localparam int QueueDepth   = 2;

  // limits and saturation points
  localparam logic [7:0]  IDLE_CLEAR_MS  = 8'd150;
  localparam logic [15:0] TIMEOUT_MAX    = 16'd60000;
  localparam logic [9:0]  THRESHOLD_MAX  = 10'd1000;
  localparam logic [15:0] ACCUM_MAX      = 16'hFFFF;
  localparam logic [7:0]  MOTION_CLK_MAX = 8'd255;
  localparam logic [14:0] KEY_CLK_MAX    = 15'h7FFF;
  localparam logic [4:0]  LAYER_MAX      = 5'(NumLayers - 1);

  // register reset values
  localparam logic        RST_ENABLED       = 1'b1;
  localparam logic [15:0] RST_DROP_DELAY    = 16'd500;
  localparam logic [9:0]  RST_THRESHOLD     = 10'd5;
  localparam logic [4:0]  RST_LAYER_INDEX   = 5'd1;
  localparam logic        RST_KEY_EXTEND    = 1'b1;
  localparam logic [14:0] RST_PRIOR_IDLE_MS = 15'd0;
  localparam logic [63:0] RST_EXCLUDED_MASK = 64'd0;

  // register indexes
  localparam logic [2:0] CFG_ENABLED       = 3'd0;
  localparam logic [2:0] CFG_DROP_DELAY    = 3'd1;
  localparam logic [2:0] CFG_THRESHOLD     = 3'd2;
  localparam logic [2:0] CFG_LAYER_INDEX   = 3'd3;
  localparam logic [2:0] CFG_KEY_EXTEND    = 3'd4;
  localparam logic [2:0] CFG_PRIOR_IDLE_MS = 3'd5;
  localparam logic [2:0] CFG_EXCLUDED_MASK = 3'd6;

  // input action codes
  localparam logic [2:0] ACT_MOTION   = 3'd0;
  localparam logic [2:0] ACT_PRESS    = 3'd1;
  localparam logic [2:0] ACT_RELEASE  = 3'd2;
  localparam logic [2:0] ACT_KEYCODE  = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;
  localparam logic [2:0] ACT_EXT_DROP = 3'd5;

  // layer event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RAISED  = 2'd1;
  localparam logic [1:0] EV_DROPPED = 2'd2;

  // classified command kinds
  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_MOTION   = 3'd1,
    KIND_PRESS    = 3'd2,
    KIND_RELEASE  = 3'd3,
    KIND_KEYCODE  = 3'd4,
    KIND_TICK     = 3'd5,
    KIND_EXT_DROP = 3'd6
  } kind_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] motion_value;
    logic [5:0]         position;
    logic               binding_transparent;
  } in_word_t;

  typedef struct packed {
    logic       layer_active;
    logic [1:0] layer_event;
    logic       pass_on;
    logic [4:0] target_layer;
  } out_word_t;

  typedef struct packed {
    logic        enabled;
    logic [15:0] drop_delay;
    logic [9:0]  threshold;
    logic [4:0]  layer_index;
    logic        key_extend;
    logic [14:0] prior_idle_ms;
    logic [63:0] excluded_mask;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] mag;
    logic [5:0]  position;
    logic        trans;
    logic        excl;
  } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/auto_mouse_layer_controller.sv
// auto-mouse layer controller: top level, register file, front, queue and back
// depends on amlc_pkg, amlc_front, amlc_queue, amlc_back
//
//   channel  direction  handshake            word
//   in_      input      in_valid/in_stall    amlc_pkg::in_word_t
//   out_     output     out_valid/out_stall  amlc_pkg::out_word_t
//   cfg_     input      cfg_valid/cfg_ready  index 3 bits, data 64 bits
//
// one word per cycle sustained while out_stall stays low; with the queue empty
// a word taken sits in a queue slot, then is executed into the result
// register, which presents it
// a two-entry queue between decode and execute absorbs output stalls; in_stall
// rises only when that queue is full
// synchronous active-low reset clears control state; registers take defaults
// register writes are always ready
`timescale 1ns / 1ps
`default_nettype none

module auto_mouse_layer_controller (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var logic                in_valid,
  output var logic                in_stall,
  input  var amlc_pkg::in_word_t  in_data,
  output var logic                out_valid,
  input  var logic                out_stall,
  output var amlc_pkg::out_word_t out_data,
  input  var logic                cfg_valid,
  output var logic                cfg_ready,
  input  var logic [2:0]          cfg_index,
  input  var logic [63:0]         cfg_wdata
);

  amlc_pkg::cfg_t cfg_r, cfg_nxt;
  amlc_pkg::cmd_t front_cmd, q_cmd;
  logic           q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;

  // register writes with saturation
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        amlc_pkg::CFG_ENABLED: cfg_nxt.enabled = cfg_wdata[0];
        amlc_pkg::CFG_DROP_DELAY:
          cfg_nxt.drop_delay = (cfg_wdata[15:0] > amlc_pkg::TIMEOUT_MAX)
                               ? amlc_pkg::TIMEOUT_MAX : cfg_wdata[15:0];
        amlc_pkg::CFG_THRESHOLD:
          cfg_nxt.threshold = (cfg_wdata[9:0] > amlc_pkg::THRESHOLD_MAX)
                              ? amlc_pkg::THRESHOLD_MAX : cfg_wdata[9:0];
        amlc_pkg::CFG_LAYER_INDEX:
          cfg_nxt.layer_index = (cfg_wdata[4:0] > amlc_pkg::LAYER_MAX)
                                ? amlc_pkg::LAYER_MAX : cfg_wdata[4:0];
        amlc_pkg::CFG_KEY_EXTEND: cfg_nxt.key_extend = cfg_wdata[0];
        amlc_pkg::CFG_PRIOR_IDLE_MS: cfg_nxt.prior_idle_ms = cfg_wdata[14:0];
        amlc_pkg::CFG_EXCLUDED_MASK: cfg_nxt.excluded_mask = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled       <= amlc_pkg::RST_ENABLED;
      cfg_r.drop_delay    <= amlc_pkg::RST_DROP_DELAY;
      cfg_r.threshold     <= amlc_pkg::RST_THRESHOLD;
      cfg_r.layer_index   <= amlc_pkg::RST_LAYER_INDEX;
      cfg_r.key_extend    <= amlc_pkg::RST_KEY_EXTEND;
      cfg_r.prior_idle_ms <= amlc_pkg::RST_PRIOR_IDLE_MS;
      cfg_r.excluded_mask <= amlc_pkg::RST_EXCLUDED_MASK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // decode
  amlc_front u_front (
    .in_word (in_data),
    .cfg     (cfg_r),
    .cmd     (front_cmd)
  );

  // command queue
  assign in_stall = q_full;

  amlc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_cmd)
  );

  // execute and result register
  amlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_data)
  );

  // a raised layer is reported as active
  a_raise_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.layer_event == amlc_pkg::EV_RAISED |-> out_data.layer_active)
    else $error("raise reported without active layer");

  // a dropped layer is reported as inactive
  a_drop_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.layer_event == amlc_pkg::EV_DROPPED |-> !out_data.layer_active)
    else $error("drop reported with active layer");

  // a swallowed key never raises the layer
  a_swallow_no_raise: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pass_on |-> out_data.layer_event != amlc_pkg::EV_RAISED)
    else $error("swallowed word raised the layer");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

### hw/rtl/amlc_front.sv
// auto-mouse layer controller: front end, decodes an input word into a command
// depends on amlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module amlc_front (
  input  var amlc_pkg::in_word_t in_word,
  input  var amlc_pkg::cfg_t     cfg,
  output var amlc_pkg::cmd_t     cmd
);

  logic [15:0] mag;
  logic        pos_ok;

  // absolute motion, -32768 gives 32768 as unsigned
  assign mag = in_word.motion_value[15] ? 16'(-in_word.motion_value)
                                        : 16'(in_word.motion_value);

  // positions beyond the key count are never excluded
  assign pos_ok = {1'b0, in_word.position} < 7'(amlc_pkg::NumPositions);

  // action decode, zero motion is a no-op
  always_comb begin
    cmd.mag      = mag;
    cmd.position = in_word.position;
    cmd.trans    = in_word.binding_transparent;
    cmd.excl     = pos_ok & cfg.excluded_mask[in_word.position];
    unique case (in_word.action)
      amlc_pkg::ACT_MOTION:   cmd.kind = (mag != 16'd0) ? amlc_pkg::KIND_MOTION
                                                        : amlc_pkg::KIND_NONE;
      amlc_pkg::ACT_PRESS:    cmd.kind = amlc_pkg::KIND_PRESS;
      amlc_pkg::ACT_RELEASE:  cmd.kind = amlc_pkg::KIND_RELEASE;
      amlc_pkg::ACT_KEYCODE:  cmd.kind = amlc_pkg::KIND_KEYCODE;
      amlc_pkg::ACT_TICK:     cmd.kind = amlc_pkg::KIND_TICK;
      amlc_pkg::ACT_EXT_DROP: cmd.kind = amlc_pkg::KIND_EXT_DROP;
      default:                cmd.kind = amlc_pkg::KIND_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/amlc_queue.sv
// auto-mouse layer controller: short command queue between front and back
// depends on amlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module amlc_queue (
  input  var logic           clk,
  input  var logic           rst_n,
  input  var logic           push,
  input  var amlc_pkg::cmd_t push_data,
  output var logic           full,
  input  var logic           pop,
  output var logic           pop_valid,
  output var amlc_pkg::cmd_t pop_data
);

  localparam int PtrW = (amlc_pkg::QueueDepth > 1) ? $clog2(amlc_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(amlc_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(amlc_pkg::QueueDepth - 1);

  amlc_pkg::cmd_t  slot_r [amlc_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = count_r == CntW'(amlc_pkg::QueueDepth);
  assign pop_valid = count_r != '0;
  assign pop_data  = slot_r[rd_ptr_r];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage slots, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/amlc_back.sv
// auto-mouse layer controller: back end, layer state, timers and result register
// depends on amlc_pkg
`timescale 1ns / 1ps
`default_nettype none

module amlc_back (
  input  var logic                clk,
  input  var logic                rst_n,
  input  var amlc_pkg::cfg_t      cfg,
  input  var logic                cmd_valid,
  input  var amlc_pkg::cmd_t      cmd,
  output var logic                cmd_pop,
  output var logic                out_valid,
  input  var logic                out_stall,
  output var amlc_pkg::out_word_t out_word
);

  logic        layer_up_r, layer_up_nxt;
  logic [15:0] accum_r, accum_nxt;
  logic [7:0]  ms_motion_r, ms_motion_nxt;
  logic [14:0] ms_key_r, ms_key_nxt;
  logic [15:0] countdown_r, countdown_nxt;
  logic        armed_r, armed_nxt;
  logic        swallow_valid_r, swallow_valid_nxt;
  logic [5:0]  swallow_key_r, swallow_key_nxt;
  logic        out_valid_r;
  amlc_pkg::out_word_t out_word_r, out_word_nxt;

  logic [15:0] accum_base;
  logic [16:0] accum_sum;
  logic [15:0] accum_sat;
  logic        trigger;
  logic        raise;
  logic        timed;
  logic [15:0] countdown_dec;
  logic [1:0]  ev;
  logic        pass;

  // take a command whenever the result register is free or draining
  assign cmd_pop   = cmd_valid & (~out_valid_r | ~out_stall);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // motion accumulate and raise decision
  assign accum_base = (ms_motion_r > amlc_pkg::IDLE_CLEAR_MS) ? 16'd0 : accum_r;
  assign accum_sum  = {1'b0, accum_base} + {1'b0, cmd.mag};
  assign accum_sat  = accum_sum[16] ? amlc_pkg::ACCUM_MAX : accum_sum[15:0];
  assign trigger    = accum_sat > {6'd0, cfg.threshold};
  assign raise      = cfg.enabled & ~layer_up_r & trigger & (ms_key_r >= cfg.prior_idle_ms);
  assign timed      = cfg.drop_delay != 16'd0;
  assign countdown_dec = (countdown_r != 16'd0) ? countdown_r - 16'd1 : 16'd0;

  // state update for one command
  always_comb begin
    layer_up_nxt      = layer_up_r;
    accum_nxt         = accum_r;
    ms_motion_nxt     = ms_motion_r;
    ms_key_nxt        = ms_key_r;
    countdown_nxt     = countdown_r;
    armed_nxt         = armed_r;
    swallow_valid_nxt = swallow_valid_r;
    swallow_key_nxt   = swallow_key_r;
    ev                = amlc_pkg::EV_NONE;
    pass              = 1'b1;
    unique case (cmd.kind)
      amlc_pkg::KIND_MOTION: begin
        ms_motion_nxt = 8'd0;
        if (cfg.enabled && !layer_up_r) begin
          accum_nxt = accum_sat;
        end
        if (raise) begin
          layer_up_nxt = 1'b1;
          ev           = amlc_pkg::EV_RAISED;
        end
        if (cfg.enabled && (layer_up_r || raise) && timed) begin
          armed_nxt     = 1'b1;
          countdown_nxt = cfg.drop_delay;
        end
      end
      amlc_pkg::KIND_PRESS: begin
        if (layer_up_r && cfg.enabled) begin
          if (cmd.excl || !cmd.trans) begin
            if (timed && cfg.key_extend) begin
              armed_nxt     = 1'b1;
              countdown_nxt = cfg.drop_delay;
            end
          end else begin
            // transparent press drops the layer; latch mode swallows it
            layer_up_nxt  = 1'b0;
            armed_nxt     = 1'b0;
            countdown_nxt = 16'd0;
            accum_nxt     = 16'd0;
            ev            = amlc_pkg::EV_DROPPED;
            if (!timed) begin
              swallow_valid_nxt = 1'b1;
              swallow_key_nxt   = cmd.position;
              pass              = 1'b0;
            end
          end
        end
      end
      amlc_pkg::KIND_RELEASE: begin
        if (swallow_valid_r && swallow_key_r == cmd.position) begin
          swallow_valid_nxt = 1'b0;
          pass              = 1'b0;
        end
      end
      amlc_pkg::KIND_KEYCODE: begin
        ms_key_nxt = 15'd0;
      end
      amlc_pkg::KIND_TICK: begin
        if (ms_motion_r != amlc_pkg::MOTION_CLK_MAX) begin
          ms_motion_nxt = ms_motion_r + 8'd1;
        end
        if (ms_key_r != amlc_pkg::KEY_CLK_MAX) begin
          ms_key_nxt = ms_key_r + 15'd1;
        end
        if (armed_r) begin
          countdown_nxt = countdown_dec;
          if (countdown_dec == 16'd0) begin
            layer_up_nxt = 1'b0;
            armed_nxt    = 1'b0;
            accum_nxt    = 16'd0;
            ev           = layer_up_r ? amlc_pkg::EV_DROPPED : amlc_pkg::EV_NONE;
          end
        end
      end
      amlc_pkg::KIND_EXT_DROP: begin
        if (layer_up_r) begin
          layer_up_nxt      = 1'b0;
          swallow_valid_nxt = 1'b0;
          armed_nxt         = 1'b0;
          countdown_nxt     = 16'd0;
        end
      end
      default: begin
      end
    endcase
    out_word_nxt.layer_active = layer_up_nxt;
    out_word_nxt.layer_event  = ev;
    out_word_nxt.pass_on      = pass;
    out_word_nxt.target_layer = cfg.layer_index;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_up_r      <= 1'b0;
      accum_r         <= 16'd0;
      ms_motion_r     <= amlc_pkg::MOTION_CLK_MAX;
      ms_key_r        <= amlc_pkg::KEY_CLK_MAX;
      countdown_r     <= 16'd0;
      armed_r         <= 1'b0;
      swallow_valid_r <= 1'b0;
      swallow_key_r   <= 6'd0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd_pop) begin
        layer_up_r      <= layer_up_nxt;
        accum_r         <= accum_nxt;
        ms_motion_r     <= ms_motion_nxt;
        ms_key_r        <= ms_key_nxt;
        countdown_r     <= countdown_nxt;
        armed_r         <= armed_nxt;
        swallow_valid_r <= swallow_valid_nxt;
        swallow_key_r   <= swallow_key_nxt;
        out_valid_r     <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule

`default_nettype wire

### tb/tb_auto_mouse_layer_controller.sv
// self-checking bench for the auto-mouse layer controller: directed words, then
// random phases under several register settings; depends on amlc_pkg and the rtl
`timescale 1ns / 1ps

module tb_auto_mouse_layer_controller;

  // action codes the block ignores
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  localparam int PhaseWords = 80;

  // layer state tracker: predicts each result word and checks what comes out
  class layer_tracker;
    bit          en;
    logic [15:0] tmo;
    logic [9:0]  thr;
    logic [4:0]  layer;
    bit          ext_on_key;
    logic [14:0] idle_need;
    logic [63:0] excl_mask;
    bit          up;
    logic [15:0] accum;
    logic [7:0]  since_motion;
    logic [14:0] since_key;
    logic [15:0] countdown;
    bit          armed;
    bit          swallowing;
    logic [5:0]  swallow_pos;
    amlc_pkg::out_word_t layer_reports[$];
    int          errors;

    function new();
      en = amlc_pkg::RST_ENABLED;
      tmo = amlc_pkg::RST_DROP_DELAY;
      thr = amlc_pkg::RST_THRESHOLD;
      layer = amlc_pkg::RST_LAYER_INDEX;
      ext_on_key = amlc_pkg::RST_KEY_EXTEND;
      idle_need = amlc_pkg::RST_PRIOR_IDLE_MS;
      excl_mask = amlc_pkg::RST_EXCLUDED_MASK;
      up = 1'b0;
      accum = '0;
      since_motion = amlc_pkg::MOTION_CLK_MAX;
      since_key = amlc_pkg::KEY_CLK_MAX;
      countdown = '0;
      armed = 1'b0;
      swallowing = 1'b0;
      swallow_pos = '0;
      errors = 0;
    endfunction

    // register writes, with the saturating fields clamped
    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        amlc_pkg::CFG_ENABLED:       en = v[0];
        amlc_pkg::CFG_DROP_DELAY:
          tmo = (v[15:0] > amlc_pkg::TIMEOUT_MAX) ? amlc_pkg::TIMEOUT_MAX : v[15:0];
        amlc_pkg::CFG_THRESHOLD:
          thr = (v[9:0] > amlc_pkg::THRESHOLD_MAX) ? amlc_pkg::THRESHOLD_MAX : v[9:0];
        amlc_pkg::CFG_LAYER_INDEX:
          layer = (v[4:0] > amlc_pkg::LAYER_MAX) ? amlc_pkg::LAYER_MAX : v[4:0];
        amlc_pkg::CFG_KEY_EXTEND:    ext_on_key = v[0];
        amlc_pkg::CFG_PRIOR_IDLE_MS: idle_need = v[14:0];
        amlc_pkg::CFG_EXCLUDED_MASK: excl_mask = v;
        default: ;
      endcase
    endfunction

    function void restart_countdown();
      armed = 1'b1;
      countdown = tmo;
    endfunction

    // drop the layer; an event only if it was up
    function logic [1:0] drop_layer();
      logic [1:0] ev;
      ev = up ? amlc_pkg::EV_DROPPED : amlc_pkg::EV_NONE;
      armed = 1'b0;
      countdown = '0;
      up = 1'b0;
      accum = '0;
      return ev;
    endfunction

    // advance the layer state by one accepted input word
    function void take_word(amlc_pkg::in_word_t w);
      logic [1:0]  ev;
      logic        pass;
      logic [15:0] raw;
      int unsigned mag;
      int unsigned sum;
      bit          active;
      bit          trigger;
      amlc_pkg::out_word_t exp_word;
      ev = amlc_pkg::EV_NONE;
      pass = 1'b1;
      raw = w.motion_value;
      active = up;
      trigger = 1'b0;
      case (w.action)
        amlc_pkg::ACT_MOTION: if (raw != 16'd0) begin
          if (en && !active) begin
            mag = raw[15] ? 32'h1_0000 - raw : raw;
            if (since_motion > amlc_pkg::IDLE_CLEAR_MS) accum = '0;
            sum = accum + mag;
            accum = (sum > amlc_pkg::ACCUM_MAX) ? amlc_pkg::ACCUM_MAX : sum[15:0];
            trigger = accum > thr;
          end
          since_motion = '0;
          if (en) begin
            if (trigger && since_key >= idle_need) begin
              if (!up) begin
                up = 1'b1;
                ev = amlc_pkg::EV_RAISED;
              end
              active = 1'b1;
            end
            if (active && tmo != 16'd0) restart_countdown();
          end
        end
        amlc_pkg::ACT_PRESS: if (up && en) begin
          if (excl_mask[w.position] || !w.binding_transparent) begin
            if (tmo != 16'd0 && ext_on_key) restart_countdown();
          end else if (tmo == 16'd0) begin
            // latch mode: the press and its later release are swallowed
            swallowing = 1'b1;
            swallow_pos = w.position;
            ev = drop_layer();
            pass = 1'b0;
          end else begin
            ev = drop_layer();
          end
        end
        amlc_pkg::ACT_RELEASE: if (swallowing && swallow_pos == w.position) begin
          swallowing = 1'b0;
          pass = 1'b0;
        end
        amlc_pkg::ACT_KEYCODE: since_key = '0;
        amlc_pkg::ACT_TICK: begin
          if (since_motion < amlc_pkg::MOTION_CLK_MAX) since_motion = since_motion + 8'd1;
          if (since_key < amlc_pkg::KEY_CLK_MAX) since_key = since_key + 15'd1;
          if (armed) begin
            if (countdown != 16'd0) countdown = countdown - 16'd1;
            if (countdown == 16'd0) ev = drop_layer();
          end
        end
        amlc_pkg::ACT_EXT_DROP: if (up) begin
          // dropped elsewhere, so no event from this block
          up = 1'b0;
          swallowing = 1'b0;
          armed = 1'b0;
          countdown = '0;
        end
        default: ;
      endcase
      exp_word.layer_active = up;
      exp_word.layer_event = ev;
      exp_word.pass_on = pass;
      exp_word.target_layer = layer;
      layer_reports.push_back(exp_word);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // compare a result word with the oldest prediction
    task check_report(amlc_pkg::out_word_t got);
      amlc_pkg::out_word_t exp_word;
      if (layer_reports.size() == 0) begin
        report($sformatf("result word %h with nothing outstanding", got));
      end else begin
        exp_word = layer_reports.pop_front();
        if (got.layer_active !== exp_word.layer_active)
          report($sformatf("layer_active %b, expected %b",
                           got.layer_active, exp_word.layer_active));
        if (got.layer_event !== exp_word.layer_event)
          report($sformatf("layer_event %0d, expected %0d",
                           got.layer_event, exp_word.layer_event));
        if (got.pass_on !== exp_word.pass_on)
          report($sformatf("pass_on %b, expected %b", got.pass_on, exp_word.pass_on));
        if (got.target_layer !== exp_word.target_layer)
          report($sformatf("target_layer %0d, expected %0d",
                           got.target_layer, exp_word.target_layer));
      end
    endtask

    task check_drained();
      if (layer_reports.size() != 0)
        report($sformatf("%0d result words never arrived", layer_reports.size()));
    endtask
  endclass

  bit                  clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  amlc_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  amlc_pkg::out_word_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [2:0]          cfg_index;
  logic [63:0]         cfg_wdata;

  layer_tracker track;
  int          in_gap_pct;
  int          out_stall_pct;
  bit          calm;
  logic [5:0]  last_pos;

  auto_mouse_layer_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // handshakes seen at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid && !out_stall) track.check_report(out_data);
      if (in_valid && !in_stall) track.take_word(in_data);
      if (cfg_valid && cfg_ready) track.write_reg(cfg_index, cfg_wdata);
    end
  end

  // result side stalls in random bursts, none in the calm phase
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 7)) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("** auto_mouse_layer_controller: FAILED **");
    $finish;
  end

  function amlc_pkg::in_word_t make_word(logic [2:0] act, logic [15:0] mv, logic [5:0] pos,
                                         logic tr);
    amlc_pkg::in_word_t w;
    w.action = act;
    w.motion_value = mv;
    w.position = pos;
    w.binding_transparent = tr;
    return w;
  endfunction

  function amlc_pkg::in_word_t noise_word();
    return amlc_pkg::in_word_t'(26'($urandom));
  endfunction

  function logic [5:0] pick_pos();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, 3));
  endfunction

  // random word, mostly the shapes that drive the layer up and down
  function amlc_pkg::in_word_t random_word();
    amlc_pkg::in_word_t w;
    int       r;
    w = noise_word();
    r = $urandom_range(0, 99);
    if (r < 36) begin
      w.action = amlc_pkg::ACT_MOTION;
      case ($urandom_range(0, 19))
        0, 1:    w.motion_value = '0;
        2, 3:    w.motion_value = 16'($urandom);
        4:       w.motion_value = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        default: w.motion_value = $urandom_range(0, 1) ? 16'($urandom_range(1, 12))
                                                        : -16'($urandom_range(1, 12));
      endcase
    end else if (r < 56) begin
      w.action = amlc_pkg::ACT_PRESS;
      w.position = pick_pos();
      w.binding_transparent = ($urandom_range(0, 2) != 0);
      last_pos = w.position;
    end else if (r < 70) begin
      w.action = amlc_pkg::ACT_RELEASE;
      w.position = ($urandom_range(0, 9) < 7) ? last_pos : pick_pos();
    end else if (r < 75) begin
      w.action = amlc_pkg::ACT_KEYCODE;
    end else if (r < 96) begin
      w.action = amlc_pkg::ACT_TICK;
    end else if (r < 98) begin
      w.action = amlc_pkg::ACT_EXT_DROP;
    end else begin
      w.action = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    end
    return w;
  endfunction

  // offer one input word, with an optional gap first
  task send(amlc_pkg::in_word_t w);
    if (!calm && in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task tick_run(int n);
    amlc_pkg::in_word_t w;
    repeat (n) begin
      w = noise_word();
      w.action = amlc_pkg::ACT_TICK;
      send(w);
    end
  endtask

  // hold off until every predicted word has come back
  task settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (track.layer_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [2:0] idx, logic [63:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_regs(logic [63:0] en, logic [63:0] tmo, logic [63:0] thr, logic [63:0] lyr,
                logic [63:0] ext, logic [63:0] idle, logic [63:0] mask);
    write_reg(amlc_pkg::CFG_ENABLED, en);
    write_reg(amlc_pkg::CFG_DROP_DELAY, tmo);
    write_reg(amlc_pkg::CFG_THRESHOLD, thr);
    write_reg(amlc_pkg::CFG_LAYER_INDEX, lyr);
    write_reg(amlc_pkg::CFG_KEY_EXTEND, ext);
    write_reg(amlc_pkg::CFG_PRIOR_IDLE_MS, idle);
    write_reg(amlc_pkg::CFG_EXCLUDED_MASK, mask);
  endtask

  initial begin
    int sent;
    int r;
    int n;
    track = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_gap_pct = 0;
    out_stall_pct = 0;
    calm = 1'b0;
    last_pos = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed: default registers
    in_gap_pct = 20;
    out_stall_pct = 20;
    send(make_word(amlc_pkg::ACT_MOTION, 16'h0000, 6'd0, 1'b1));   // zero motion is ignored
    send(make_word(ACT_SPARE_A, 16'h1234, 6'd3, 1'b1));
    send(make_word(ACT_SPARE_B, 16'hFFFF, 6'd63, 1'b0));
    send(make_word(amlc_pkg::ACT_MOTION, 16'd3, 6'd0, 1'b0));
    send(make_word(amlc_pkg::ACT_MOTION, 16'h8000, 6'd0, 1'b0));   // most negative, raises
    send(make_word(amlc_pkg::ACT_MOTION, 16'h7FFF, 6'd0, 1'b0));   // motion while up
    send(make_word(amlc_pkg::ACT_PRESS, 16'd0, 6'd63, 1'b0));      // opaque key extends
    send(make_word(amlc_pkg::ACT_PRESS, 16'd0, 6'd5, 1'b1));       // transparent key drops
    send(make_word(amlc_pkg::ACT_RELEASE, 16'd0, 6'd5, 1'b1));     // not swallowed
    send(make_word(amlc_pkg::ACT_MOTION, 16'hFFFF, 6'd0, 1'b1));
    send(make_word(amlc_pkg::ACT_MOTION, 16'd10, 6'd0, 1'b1));
    send(make_word(amlc_pkg::ACT_KEYCODE, 16'd0, 6'd0, 1'b0));
    send(make_word(amlc_pkg::ACT_EXT_DROP, 16'd0, 6'd0, 1'b0));    // dropped elsewhere
    send(make_word(amlc_pkg::ACT_EXT_DROP, 16'd0, 6'd0, 1'b0));
    send(make_word(amlc_pkg::ACT_TICK, 16'd0, 6'd0, 1'b0));
    settle();
    // countdown end and an excluded key
    set_regs(1, 2, 0, 31, 0, 0, 64'h200);
    send(make_word(amlc_pkg::ACT_MOTION, 16'd1, 6'd0, 1'b0));
    send(make_word(amlc_pkg::ACT_PRESS, 16'd0, 6'd9, 1'b1));
    send(make_word(amlc_pkg::ACT_TICK, 16'd0, 6'd0, 1'b0));
    send(make_word(amlc_pkg::ACT_TICK, 16'd0, 6'd0, 1'b0));
    settle();
    // latch mode: swallowed press and release
    set_regs(1, 0, 0, 0, 1, 0, 64'h200);
    send(make_word(amlc_pkg::ACT_MOTION, 16'd1, 6'd0, 1'b0));
    send(make_word(amlc_pkg::ACT_PRESS, 16'd0, 6'd9, 1'b1));
    send(make_word(amlc_pkg::ACT_PRESS, 16'd0, 6'd7, 1'b1));
    send(make_word(amlc_pkg::ACT_RELEASE, 16'd0, 6'd7, 1'b1));
    send(make_word(amlc_pkg::ACT_RELEASE, 16'd0, 6'd7, 1'b1));
    settle();
    // motion while disabled
    write_reg(amlc_pkg::CFG_ENABLED, 0);
    send(make_word(amlc_pkg::ACT_MOTION, 16'd5, 6'd0, 1'b0));
    settle();
    // accumulator cleared after a long motion idle
    write_reg(amlc_pkg::CFG_ENABLED, 1);
    write_reg(amlc_pkg::CFG_THRESHOLD, 5);
    send(make_word(amlc_pkg::ACT_MOTION, 16'd3, 6'd0, 1'b0));
    tick_run(151);
    send(make_word(amlc_pkg::ACT_MOTION, 16'd3, 6'd0, 1'b0));
    settle();

    // random phases, one register setting each
    for (int ph = 0; ph < 7; ph++) begin
      calm = (ph == 6);
      r = $urandom_range(0, 2);
      in_gap_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
      r = $urandom_range(0, 2);
      out_stall_pct = (r == 0) ? 0 : (r == 1) ? 10 : 35;
      case (ph)
        0: set_regs(1, 20, 5, 3, 1, 0, {$urandom, $urandom});
        1: set_regs(1, 0, 0, 0, 1, 0, {$urandom, $urandom});
        2: set_regs(1, 16'hFFFF, 10'h3FF, 31, 0, 15'h7FFF, '1);
        3: set_regs(0, $urandom_range(1, 30), $urandom_range(0, 20),
                    $urandom_range(0, 31), 1, 0, {$urandom, $urandom});
        4: set_regs(1, $urandom_range(1, 30), $urandom_range(0, 40),
                    $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 30),
                    {$urandom, $urandom});
        5: set_regs(1, 1, 1000, 2, 1, $urandom_range(0, 10), 0);
        default: set_regs(1, $urandom_range(0, 1) ? 0 : $urandom_range(1, 25),
                          $urandom_range(0, 20), $urandom_range(0, 31),
                          $urandom_range(0, 1), $urandom_range(0, 20),
                          {$urandom, $urandom});
      endcase
      sent = 0;
      while (sent < PhaseWords) begin
        r = $urandom_range(0, 199);
        if (r < 8) begin
          n = $urandom_range(1, 25);              // long enough for short countdowns
          tick_run(n);
          sent += n;
        end else if (r == 8) begin
          n = $urandom_range(150, 165);           // at or past the motion idle clear
          tick_run(n);
          sent += n;
        end else begin
          send(random_word());
          sent++;
        end
      end
      settle();
    end

    repeat (6) @(posedge clk);
    track.check_drained();
    if (track.errors == 0) begin
      $display("** auto_mouse_layer_controller: PASSED **");
    end else begin
      $display("** auto_mouse_layer_controller: FAILED **");
    end
    $finish;
  end

endmodule
